// ----- hdl/rmcp_pkg.sv -----
// ----------------------------------------------------------------------------
// rmcp_pkg
// Shared types, phase codes and status decoding for the RTP-MIDI command
// section parser.
// ----------------------------------------------------------------------------
package rmcp_pkg;

    localparam logic [6:0] PT_MATCH_RESET = 7'd97;
    localparam int         QUEUE_DEPTH    = 3;

    typedef enum logic [8:0] {
        PH_HEADER  = 9'b000000001,
        PH_LONGLEN = 9'b000000010,
        PH_CMD     = 9'b000000100,
        PH_DELTA   = 9'b000001000,
        PH_DATA1   = 9'b000010000,
        PH_DATA2   = 9'b000100000,
        PH_SYSEX   = 9'b001000000,
        PH_SKIP1   = 9'b010000000,
        PH_IDLE    = 9'b100000000
    } phase_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_ONE   = 2'd1,
        CLS_TWO   = 2'd2,
        CLS_SYSEX = 2'd3
    } status_class_t;

    localparam logic KIND_MESSAGE = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;

    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_REALTIME    = 8'hF8;
    localparam logic [1:0] HDR_VERSION    = 2'd2;
    localparam logic [3:0] HEADER_LAST    = 4'd12;

    typedef struct packed {
        logic       kind;
        logic [7:0] status_byte;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic       last_of_run;
    } result_t;

    function automatic status_class_t status_class(input logic [7:0] st);
        status_class_t cls;
        cls = CLS_OTHER;
        if (st[7:4] >= 4'h8 && st[7:4] <= 4'hB)
            cls = CLS_TWO;
        else if (st[7:4] == 4'hC || st[7:4] == 4'hD)
            cls = CLS_ONE;
        else if (st[7:4] == 4'hE)
            cls = CLS_TWO;
        else if (st == ST_SYSEX_START)
            cls = CLS_SYSEX;
        return cls;
    endfunction

endpackage

// ----- hdl/rmcp_parser.sv -----
// ----------------------------------------------------------------------------
// rmcp_parser
// Packet parse state and the per-byte update: RTP header check, MIDI list
// header, delta skip, running status, message and flush marker results.
// ----------------------------------------------------------------------------
module rmcp_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           packet_byte,
    input  logic                 end_of_packet,
    input  logic [6:0]           pt_match,
    output logic [1:0]           res_count,
    output rmcp_pkg::result_t    res0,
    output rmcp_pkg::result_t    res1
);

    rmcp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       pos_reg, pos_next;
    logic [11:0]      left_reg, left_next;
    logic [7:0]       running_reg, running_next;
    logic [15:0]      held_reg, held_next;
    logic             rejected_reg, rejected_next;
    logic             emitted_reg, emitted_next;

    logic             msg;
    logic [7:0]       msg_status;
    logic [7:0]       msg_d1;
    logic [7:0]       msg_d2;
    logic             flush;

    always_comb
    begin
        logic [11:0]              left_dec;
        rmcp_pkg::status_class_t  cls;
        logic                     emit_any;

        phase_next    = phase_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        running_next  = running_reg;
        held_next     = held_reg;
        rejected_next = rejected_reg;
        emitted_next  = emitted_reg;
        msg           = 1'b0;
        msg_status    = 8'd0;
        msg_d1        = 8'd0;
        msg_d2        = 8'd0;
        flush         = 1'b0;
        left_dec      = left_reg - 12'd1;
        cls           = rmcp_pkg::CLS_OTHER;
        emit_any      = 1'b0;

        case (phase_reg)
            rmcp_pkg::PH_HEADER:
            begin
                if (pos_reg == 4'd0)
                begin
                    if (packet_byte[7:6] != rmcp_pkg::HDR_VERSION)
                        rejected_next = 1'b1;
                end
                else if (pos_reg == 4'd1)
                begin
                    if (packet_byte[6:0] != pt_match)
                        rejected_next = 1'b1;
                end
                else if (pos_reg == rmcp_pkg::HEADER_LAST)
                begin
                    if (rejected_reg)
                        phase_next = rmcp_pkg::PH_IDLE;
                    else if (packet_byte[7])
                    begin
                        left_next  = {packet_byte[3:0], 8'd0};
                        phase_next = rmcp_pkg::PH_LONGLEN;
                    end
                    else if (packet_byte[3:0] == 4'd0)
                    begin
                        rejected_next = 1'b1;
                        phase_next    = rmcp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        left_next  = {8'd0, packet_byte[3:0]};
                        phase_next = rmcp_pkg::PH_CMD;
                    end
                end
                if (pos_reg < rmcp_pkg::HEADER_LAST)
                    pos_next = pos_reg + 4'd1;
            end
            rmcp_pkg::PH_LONGLEN:
            begin
                left_next = {left_reg[11:8], packet_byte};
                if ({left_reg[11:8], packet_byte} == 12'd0)
                begin
                    rejected_next = 1'b1;
                    phase_next    = rmcp_pkg::PH_IDLE;
                end
                else
                    phase_next = rmcp_pkg::PH_CMD;
            end
            rmcp_pkg::PH_CMD, rmcp_pkg::PH_DELTA, rmcp_pkg::PH_DATA1,
            rmcp_pkg::PH_DATA2, rmcp_pkg::PH_SYSEX, rmcp_pkg::PH_SKIP1:
            begin
                if (left_reg == 12'd0)
                    phase_next = rmcp_pkg::PH_IDLE;
                else
                begin
                    case (phase_reg)
                        rmcp_pkg::PH_CMD:
                        begin
                            if (packet_byte >= rmcp_pkg::ST_REALTIME)
                            begin
                                msg        = 1'b1;
                                msg_status = packet_byte;
                                phase_next = rmcp_pkg::PH_DELTA;
                            end
                            else if (packet_byte[7])
                            begin
                                running_next = packet_byte;
                                held_next    = {packet_byte, 8'd0};
                                cls          = rmcp_pkg::status_class(packet_byte);
                                if (cls == rmcp_pkg::CLS_SYSEX)
                                    phase_next = rmcp_pkg::PH_SYSEX;
                                else if (cls == rmcp_pkg::CLS_OTHER)
                                    phase_next = rmcp_pkg::PH_SKIP1;
                                else
                                    phase_next = rmcp_pkg::PH_DATA1;
                            end
                            else if (running_reg == 8'd0)
                                phase_next = rmcp_pkg::PH_DELTA;
                            else
                            begin
                                cls = rmcp_pkg::status_class(running_reg);
                                case (cls)
                                    rmcp_pkg::CLS_TWO:
                                    begin
                                        held_next  = {running_reg, packet_byte};
                                        phase_next = rmcp_pkg::PH_DATA2;
                                    end
                                    rmcp_pkg::CLS_ONE:
                                    begin
                                        msg        = 1'b1;
                                        msg_status = running_reg;
                                        msg_d1     = packet_byte;
                                        phase_next = rmcp_pkg::PH_DELTA;
                                    end
                                    rmcp_pkg::CLS_SYSEX:
                                        phase_next = rmcp_pkg::PH_SYSEX;
                                    default:
                                        phase_next = rmcp_pkg::PH_DELTA;
                                endcase
                            end
                        end
                        rmcp_pkg::PH_DELTA:
                        begin
                            if (!packet_byte[7])
                                phase_next = rmcp_pkg::PH_CMD;
                        end
                        rmcp_pkg::PH_DATA1:
                        begin
                            cls = rmcp_pkg::status_class(held_reg[15:8]);
                            if (cls == rmcp_pkg::CLS_TWO)
                            begin
                                held_next  = {held_reg[15:8], packet_byte};
                                phase_next = rmcp_pkg::PH_DATA2;
                            end
                            else
                            begin
                                msg        = 1'b1;
                                msg_status = held_reg[15:8];
                                msg_d1     = packet_byte;
                                phase_next = rmcp_pkg::PH_DELTA;
                            end
                        end
                        rmcp_pkg::PH_DATA2:
                        begin
                            msg        = 1'b1;
                            msg_status = held_reg[15:8];
                            msg_d1     = held_reg[7:0];
                            msg_d2     = packet_byte;
                            phase_next = rmcp_pkg::PH_DELTA;
                        end
                        rmcp_pkg::PH_SYSEX:
                        begin
                            if (packet_byte == rmcp_pkg::ST_SYSEX_END)
                                phase_next = rmcp_pkg::PH_DELTA;
                        end
                        default:
                            phase_next = rmcp_pkg::PH_DELTA;
                    endcase
                    left_next = left_dec;
                    if (left_dec == 12'd0)
                        phase_next = rmcp_pkg::PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        emit_any     = emitted_reg | msg;
        emitted_next = emit_any;

        if (end_of_packet)
        begin
            if (!rejected_next && phase_next != rmcp_pkg::PH_HEADER &&
                phase_next != rmcp_pkg::PH_LONGLEN && emit_any)
            begin
                flush        = 1'b1;
                emitted_next = 1'b0;
            end
            phase_next    = rmcp_pkg::PH_HEADER;
            pos_next      = 4'd0;
            left_next     = 12'd0;
            running_next  = 8'd0;
            held_next     = 16'd0;
            rejected_next = 1'b0;
        end
    end

    always_comb
    begin
        res_count = {1'b0, msg} + {1'b0, flush};

        res1.kind        = rmcp_pkg::KIND_FLUSH;
        res1.status_byte = 8'd0;
        res1.first_data  = 8'd0;
        res1.second_data = 8'd0;
        res1.last_of_run = 1'b1;

        if (msg)
        begin
            res0.kind        = rmcp_pkg::KIND_MESSAGE;
            res0.status_byte = msg_status;
            res0.first_data  = msg_d1;
            res0.second_data = msg_d2;
            res0.last_of_run = !flush;
        end
        else
            res0 = res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rmcp_pkg::PH_HEADER;
            pos_reg      <= 4'd0;
            left_reg     <= 12'd0;
            running_reg  <= 8'd0;
            held_reg     <= 16'd0;
            rejected_reg <= 1'b0;
            emitted_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            left_reg     <= left_next;
            running_reg  <= running_next;
            held_reg     <= held_next;
            rejected_reg <= rejected_next;
            emitted_reg  <= emitted_next;
        end
    end

    a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_count == 2'd2) |-> end_of_packet)
        else $error("two results from a byte that does not end the packet");

    a_flush_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !end_of_packet && res_count != 2'd0) |-> (res0.kind == rmcp_pkg::KIND_MESSAGE))
        else $error("flush marker before packet end");

    a_header_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_of_packet) |=> (phase_reg == rmcp_pkg::PH_HEADER && pos_reg == 4'd0))
        else $error("parser not back in header phase after packet end");

    a_flush_clears_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_of_packet && res_count != 2'd0 && res1.kind == rmcp_pkg::KIND_FLUSH
         && (res_count == 2'd2 || res0.kind == rmcp_pkg::KIND_FLUSH)) |=> !emitted_reg)
        else $error("emitted mark kept after flush marker");

endmodule

// ----- hdl/rmcp_out_queue.sv -----
// ----------------------------------------------------------------------------
// rmcp_out_queue
// Three-entry shift queue for result items: takes up to two results per
// cycle, presents the head on the output stream.
// ----------------------------------------------------------------------------
module rmcp_out_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [1:0]           push_count,
    input  rmcp_pkg::result_t    push0,
    input  rmcp_pkg::result_t    push1,
    output logic [1:0]           count,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // second_data, first_data, status_byte
    output logic                 m_tuser,   // kind
    output logic                 m_tlast    // last_of_run
);

    rmcp_pkg::result_t entry_reg [rmcp_pkg::QUEUE_DEPTH];
    rmcp_pkg::result_t entry_next [rmcp_pkg::QUEUE_DEPTH];
    logic [1:0]        count_reg, count_next;
    logic              pop;
    logic [1:0]        base;
    logic [1:0]        added;

    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign count    = count_reg;
    assign m_tdata  = {entry_reg[0].second_data, entry_reg[0].first_data,
                       entry_reg[0].status_byte};
    assign m_tuser  = entry_reg[0].kind;
    assign m_tlast  = entry_reg[0].last_of_run;

    always_comb
    begin
        base       = count_reg - {1'b0, pop};
        added      = push ? push_count : 2'd0;
        count_next = base + added;
        for (int i = 0; i < rmcp_pkg::QUEUE_DEPTH; i++)
        begin
            if (pop && i < rmcp_pkg::QUEUE_DEPTH - 1)
                entry_next[i] = entry_reg[i + 1];
            else
                entry_next[i] = entry_reg[i];
            if (added != 2'd0 && 2'(i) == base)
                entry_next[i] = push0;
            if (added == 2'd2 && 2'(i) == base + 2'd1)
                entry_next[i] = push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < rmcp_pkg::QUEUE_DEPTH; i++)
            entry_reg[i] <= entry_next[i];
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ({1'b0, count_reg} + {1'b0, push_count}) <= 3'(rmcp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (!push || push_count == 2'd0)) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue count did not drop on pop");

    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(entry_reg[0]) && m_tvalid))
        else $error("stalled head item changed");

endmodule

// ----- hdl/rtp_midi_command_parser.sv -----
// ----------------------------------------------------------------------------
// rtp_midi_command_parser
// Parses the MIDI command section of RTP-MIDI packets fed one byte per item
// and emits MIDI messages and per-packet flush markers.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then the parser's
// results for it are written into the result queue, whose head is the output.
// Throughput: 1 input item per cycle; the parser state update is a single
// pass between the input register and the 3-entry result queue, and input
// holds only while the queue lacks room for the waiting byte's results.
// A byte that yields a message and a flush marker puts two items on the output.
// Reset: parse state clears, the payload type match returns to 97.
// ----------------------------------------------------------------------------
module rtp_midi_command_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // packet_byte
    input  logic        s_tlast,    // end_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // second_data, first_data, status_byte
    output logic        m_tuser,    // kind
    output logic        m_tlast,    // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data    // RTP payload type to match
);

    logic [6:0]        pt_match_reg;
    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              accept;
    logic              advance;
    logic [1:0]        res_count;
    logic [1:0]        q_count;
    rmcp_pkg::result_t res0;
    rmcp_pkg::result_t res1;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg &&
                       (({1'b0, q_count} + {1'b0, res_count}) <= 3'(rmcp_pkg::QUEUE_DEPTH));
    assign s_tready  = !in_valid_reg || advance;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_match_reg <= rmcp_pkg::PT_MATCH_RESET;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                pt_match_reg <= cfg_data;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rmcp_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .packet_byte   (in_byte_reg),
        .end_of_packet (in_last_reg),
        .pt_match      (pt_match_reg),
        .res_count     (res_count),
        .res0          (res0),
        .res1          (res1)
    );

    rmcp_out_queue u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .count      (q_count),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
                                        && $stable(in_last_reg)))
        else $error("waiting input item lost or changed");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == 2'd0) |-> s_tready)
        else $error("input stalled with empty result queue");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (pt_match_reg == $past(cfg_data)))
        else $error("payload type write not taken");

endmodule
